FILE: hdl/pale_pkg.sv
`timescale 1ns / 1ps

package pale_pkg;

    localparam int CAPACITY  = 128;
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int LEN_BITS  = ADDR_BITS + 1;
    localparam int WORD_BITS = 32;

    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_DELETE = 3'd1;
    localparam logic [2:0] FUNC_SET    = 3'd2;
    localparam logic [2:0] FUNC_GET    = 3'd3;
    localparam logic [2:0] FUNC_LOCATE = 3'd4;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BADPOS = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_GET_CAP,
        ST_LOC_RD,
        ST_LOC_CMP,
        ST_FINISH
    } state_t;

endpackage

FILE: hdl/pale_if.sv
`timescale 1ns / 1ps

interface pale_in_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  func;
    logic        [7:0]  pos;
    logic signed [31:0] value;

    modport source (output valid, output func, output pos, output value, input ready);
    modport sink (input valid, input func, input pos, input value, output ready);
endinterface

interface pale_out_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [31:0] data;
    logic               found;
    logic        [6:0]  index;
    logic        [7:0]  count;

    modport source (
        output valid, output status, output data, output found, output index,
        output count, input ready
    );
    modport sink (
        input valid, input status, input data, input found, input index,
        input count, output ready
    );
endinterface

FILE: hdl/positional_array_list_engine_core.sv
`timescale 1ns / 1ps

// Channel  Role  Beat contents
// req      sink  func, pos, value
// rsp      src   status, data, found, index, count
//
// One request at a time runs through a store with one write port and one registered read port.
// Insert and delete move every entry from the position to the end; locate scans from entry 0
// to a match or the end; get reads the entry, and set and a rejected request go to ST_FINISH.
// Each moved entry takes a read state and a write state, each compared entry a read and a compare.
// Reset clears the length and the control state; the store contents need no clearing.
// The result sits in an output register, so a new request is taken while it waits on rsp;
// a second finished result waits in its last state until that register frees.

module positional_array_list_engine_core (
    input  logic              clk,
    input  logic              rst_n,
    pale_in_if.sink           req,
    pale_out_if.source        rsp
);

    localparam int AB = pale_pkg::ADDR_BITS;
    localparam int LB = pale_pkg::LEN_BITS;
    localparam int WB = pale_pkg::WORD_BITS;

    pale_pkg::state_t state_reg, state_next;

    logic [LB-1:0] len_reg, len_next;
    logic [LB-1:0] k_reg, k_next;
    logic [LB-1:0] pos_reg, pos_next;
    logic [WB-1:0] value_reg, value_next;
    logic [1:0]    status_reg, status_next;
    logic [WB-1:0] data_reg, data_next;
    logic          found_reg, found_next;
    logic [AB-1:0] index_reg, index_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic [WB-1:0] out_data_reg, out_data_next;
    logic          out_found_reg, out_found_next;
    logic [AB-1:0] out_index_reg, out_index_next;
    logic [LB-1:0] out_count_reg, out_count_next;

    logic          ram_we;
    logic [AB-1:0] ram_waddr;
    logic [WB-1:0] ram_wdata;
    logic [AB-1:0] ram_raddr;
    logic [WB-1:0] ram_rdata;

    logic          accept;
    logic          out_free;
    logic [1:0]    req_status;
    logic [LB-1:0] k_dec;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign k_dec    = k_reg - LB'(1);

    always_comb
    begin
        req_status = pale_pkg::STATUS_OK;
        case (req.func)
            pale_pkg::FUNC_INSERT:
            begin
                if (req.pos > len_reg)
                begin
                    req_status = pale_pkg::STATUS_BADPOS;
                end
                else if (len_reg >= LB'(pale_pkg::CAPACITY))
                begin
                    req_status = pale_pkg::STATUS_FULL;
                end
            end
            pale_pkg::FUNC_DELETE, pale_pkg::FUNC_SET, pale_pkg::FUNC_GET:
            begin
                if (req.pos >= len_reg)
                begin
                    req_status = pale_pkg::STATUS_BADPOS;
                end
            end
            default:
            begin
                req_status = pale_pkg::STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pale_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_status != pale_pkg::STATUS_OK)
                    begin
                        state_next = pale_pkg::ST_FINISH;
                    end
                    else
                    begin
                        case (req.func)
                            pale_pkg::FUNC_INSERT: state_next = pale_pkg::ST_INS_RD;
                            pale_pkg::FUNC_DELETE: state_next = pale_pkg::ST_DEL_RD;
                            pale_pkg::FUNC_GET:    state_next = pale_pkg::ST_GET_CAP;
                            pale_pkg::FUNC_LOCATE: state_next = pale_pkg::ST_LOC_RD;
                            default:               state_next = pale_pkg::ST_FINISH;
                        endcase
                    end
                end
            end
            pale_pkg::ST_INS_RD:
            begin
                state_next = (k_reg == pos_reg) ? pale_pkg::ST_FINISH : pale_pkg::ST_INS_WR;
            end
            pale_pkg::ST_INS_WR:
            begin
                state_next = pale_pkg::ST_INS_RD;
            end
            pale_pkg::ST_DEL_RD:
            begin
                state_next = (k_reg == len_reg) ? pale_pkg::ST_FINISH : pale_pkg::ST_DEL_WR;
            end
            pale_pkg::ST_DEL_WR:
            begin
                state_next = pale_pkg::ST_DEL_RD;
            end
            pale_pkg::ST_GET_CAP:
            begin
                state_next = pale_pkg::ST_FINISH;
            end
            pale_pkg::ST_LOC_RD:
            begin
                state_next = (k_reg == len_reg) ? pale_pkg::ST_FINISH : pale_pkg::ST_LOC_CMP;
            end
            pale_pkg::ST_LOC_CMP:
            begin
                state_next = (ram_rdata == value_reg) ? pale_pkg::ST_FINISH
                                                      : pale_pkg::ST_LOC_RD;
            end
            pale_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = pale_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pale_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        len_next        = len_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        data_next       = data_reg;
        found_next      = found_reg;
        index_next      = index_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_found_next  = out_found_reg;
        out_index_next  = out_index_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = k_reg[AB-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = k_reg[AB-1:0];

        case (state_reg)
            pale_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next    = req.pos;
                    value_next  = req.value;
                    status_next = req_status;
                    data_next   = '0;
                    found_next  = 1'b0;
                    index_next  = '0;
                    case (req.func)
                        pale_pkg::FUNC_INSERT: k_next = len_reg;
                        pale_pkg::FUNC_DELETE: k_next = req.pos;
                        pale_pkg::FUNC_LOCATE: k_next = '0;
                        default:               k_next = k_reg;
                    endcase
                    if (req_status == pale_pkg::STATUS_OK && req.func == pale_pkg::FUNC_SET)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = req.pos[AB-1:0];
                        ram_wdata = req.value;
                    end
                    ram_raddr = req.pos[AB-1:0];
                end
            end
            pale_pkg::ST_INS_RD:
            begin
                ram_raddr = k_dec[AB-1:0];
                if (k_reg == pos_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg[AB-1:0];
                    ram_wdata = value_reg;
                    len_next  = len_reg + LB'(1);
                end
            end
            pale_pkg::ST_INS_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg[AB-1:0];
                k_next    = k_dec;
            end
            pale_pkg::ST_DEL_RD:
            begin
                if (k_reg == len_reg)
                begin
                    len_next = len_reg - LB'(1);
                end
            end
            pale_pkg::ST_DEL_WR:
            begin
                if (k_reg == pos_reg)
                begin
                    data_next = ram_rdata;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = k_dec[AB-1:0];
                end
                k_next = k_reg + LB'(1);
            end
            pale_pkg::ST_GET_CAP:
            begin
                data_next = ram_rdata;
            end
            pale_pkg::ST_LOC_CMP:
            begin
                if (ram_rdata == value_reg)
                begin
                    found_next = 1'b1;
                    index_next = k_reg[AB-1:0];
                end
                else
                begin
                    k_next = k_reg + LB'(1);
                end
            end
            pale_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_data_next   = data_reg;
                    out_found_next  = found_reg;
                    out_index_next  = index_reg;
                    out_count_next  = len_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pale_pkg::ST_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        pos_reg        <= pos_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        data_reg       <= data_next;
        found_reg      <= found_next;
        index_reg      <= index_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_found_reg  <= out_found_next;
        out_index_reg  <= out_index_next;
        out_count_reg  <= out_count_next;
    end

    pale_ram #(
        .DEPTH (pale_pkg::CAPACITY),
        .WIDTH (pale_pkg::WORD_BITS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready  = (state_reg == pale_pkg::ST_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.found  = out_found_reg;
    assign rsp.index  = out_index_reg;
    assign rsp.count  = out_count_reg;

    // The length can never pass the store capacity.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LB'(pale_pkg::CAPACITY))
        else $error("list length exceeds capacity");

    // A locate compare only ever looks at an entry that is inside the list.
    a_loc_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pale_pkg::ST_LOC_CMP |-> k_reg < len_reg)
        else $error("locate compares beyond the list");

    // An insert shift only runs on a list with room and above the insert position.
    a_ins_shift: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pale_pkg::ST_INS_WR
            |-> (len_reg < LB'(pale_pkg::CAPACITY) && k_reg > pos_reg))
        else $error("insert shift out of range");

    // A finished result is loaded only when the output register is free.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pale_pkg::ST_FINISH && out_valid_reg && !rsp.ready)
            |=> state_reg == pale_pkg::ST_FINISH)
        else $error("result dropped while output stalled");

endmodule

FILE: hdl/pale_ram.sv
`timescale 1ns / 1ps

module pale_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
